/* rtl/dkgs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkgs_pkg
// Shared types and constants of the distinct key group splitter.
// ----------------------------------------------------------------------------
package dkgs_pkg;

	localparam int SUBJ_W       = 16;
	localparam int GROUP_W      = 16;
	localparam int CFG_W        = 5;
	localparam int MAX_KEYS_DEF = 16;
	localparam int KEY_BITS_DEF = 16;
	localparam int LIMIT_MIN    = 2;
	localparam int RES_DEPTH    = 2;
	localparam int APB_AW       = 3;
	localparam int APB_DW       = 32;

	localparam logic [GROUP_W-1:0] GROUP_MAX     = {GROUP_W{1'b1}};
	localparam logic [CFG_W-1:0]   CFG_RESET     = 5'd2;
	localparam logic [APB_AW-1:0]  ADDR_SUBJECTS = 3'd0;

	typedef struct packed {
		logic [SUBJ_W-1:0] subject_key;
		logic              start_of_set;
	} in_item_t;

	typedef struct packed {
		logic [GROUP_W-1:0] group_number;
		logic               opened_group;
		logic               new_key;
	} out_item_t;

endpackage

/* rtl/distinct_key_group_splitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_key_group_splitter
// Tags a key-sorted item stream with group numbers, bounded distinct keys.
// ----------------------------------------------------------------------------
// A taken request's result is registered in the result queue on the accepting edge.
// Throughput: one request per cycle while full is low; the key compare over the
// whole store and the group update finish in the accept cycle, and the two-entry
// result queue holds results while pop is low, raising full once both entries hold one.
// Reset: clears key count, group number, queue; limit register returns to 2.
module distinct_key_group_splitter import dkgs_pkg::*; #(
	parameter int MAX_KEYS = MAX_KEYS_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              push,
	output logic              full,
	input  in_item_t          item,
	input  logic              pop,
	output logic              empty,
	output out_item_t         result
);

	logic [CFG_W-1:0] limit_q;
	logic             sel_subj;
	logic             acc;
	out_item_t        res;

	assign pready   = 1'b1;
	assign sel_subj = (paddr[APB_AW-1:2] == ADDR_SUBJECTS[APB_AW-1:2]);
	assign prdata   = sel_subj ? APB_DW'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= CFG_RESET;
		end else if (psel && penable && pwrite && pready && sel_subj) begin
			limit_q <= pwdata[CFG_W-1:0];
		end
	end

	assign acc = push && !full;

	dkgs_classifier #(
		.MAX_KEYS (MAX_KEYS),
		.KEY_BITS (KEY_BITS)
	) u_classifier (
		.clk    (clk),
		.arst_n (arst_n),
		.limit  (limit_q),
		.acc    (acc),
		.item   (item),
		.res    (res)
	);

	dkgs_fifo #(
		.DEPTH (RES_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (acc),
		.wdata  (res),
		.full   (full),
		.rd     (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

/* rtl/dkgs_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkgs_classifier
// Front part: key set with parallel compare, group counter, result build.
// ----------------------------------------------------------------------------
module dkgs_classifier import dkgs_pkg::*; #(
	parameter int MAX_KEYS = MAX_KEYS_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] limit,
	input  logic             acc,
	input  in_item_t         item,
	output out_item_t        res
);

	localparam int CMP_BITS = (KEY_BITS < SUBJ_W) ? KEY_BITS : SUBJ_W;
	localparam int CNT_W    = $clog2(MAX_KEYS + 1);
	localparam int IDX_W    = $clog2(MAX_KEYS);
	localparam int LIM_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic [CMP_BITS-1:0] store_q [MAX_KEYS];
	logic [CNT_W-1:0]    held_q;
	logic [GROUP_W-1:0]  group_q;

	logic [CMP_BITS-1:0] key;
	logic                start;
	logic [CNT_W-1:0]    held_eff;
	logic [GROUP_W-1:0]  group_eff;
	logic [GROUP_W-1:0]  group_nxt;
	logic [MAX_KEYS-1:0] match;
	logic                hit;
	logic                fresh;
	logic                full_set;
	logic                opened;
	logic [LIM_W-1:0]    cfg_ext;
	logic [LIM_W-1:0]    lim;
	logic [IDX_W-1:0]    wr_idx;

	assign key   = item.subject_key[CMP_BITS-1:0];
	assign start = item.start_of_set;

	assign held_eff  = start ? '0 : held_q;
	assign group_eff = start ? '0 : group_q;

	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cmp
		assign match[i] = (CNT_W'(i) < held_q) && (store_q[i] == key);
	end

	assign hit   = !start && (|match);
	assign fresh = !hit;

	assign cfg_ext = LIM_W'(limit);
	always_comb begin
		priority if (cfg_ext < LIM_W'(LIMIT_MIN)) begin
			lim = LIM_W'(LIMIT_MIN);
		end else if (cfg_ext > LIM_W'(MAX_KEYS)) begin
			lim = LIM_W'(MAX_KEYS);
		end else begin
			lim = cfg_ext;
		end
	end

	assign full_set = fresh && (LIM_W'(held_eff) >= lim);
	assign opened   = (held_eff == '0) || full_set;
	assign wr_idx   = full_set ? '0 : held_eff[IDX_W-1:0];

	always_comb begin
		group_nxt = group_eff;
		if (full_set && group_eff != GROUP_MAX) begin
			group_nxt = group_eff + 1'b1;
		end
	end

	assign res.group_number = group_nxt;
	assign res.opened_group = opened;
	assign res.new_key      = fresh;

	always_ff @(posedge clk) begin
		if (acc && fresh) begin
			store_q[wr_idx] <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			group_q <= '0;
		end else if (acc) begin
			group_q <= group_nxt;
			if (full_set) begin
				held_q <= CNT_W'(1);
			end else if (fresh) begin
				held_q <= held_eff + 1'b1;
			end else begin
				held_q <= held_eff;
			end
		end
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(MAX_KEYS))
		else $error("key count above store depth");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && start |=> group_q == '0 && held_q == CNT_W'(1))
		else $error("start of set did not reset group state");

	a_hit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		acc && hit |=> held_q == $past(held_q) && group_q == $past(group_q))
		else $error("known key changed group state");

endmodule

/* rtl/dkgs_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkgs_fifo
// Back part: short result queue between classifier and result port.
// ----------------------------------------------------------------------------
module dkgs_fifo import dkgs_pkg::*; #(
	parameter int DEPTH = RES_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  out_item_t wdata,
	output logic      full,
	input  logic      rd,
	output out_item_t rdata,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	out_item_t      mem_q [DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr;
	logic           do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count overflow");

	a_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a request");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the distinct key group splitter. Key-sorted data
// sets, noise requests and a calm run at the smallest limit are pushed into
// the splitter while the limit register is changed over APB between phases.
// A scoreboard tracks the distinct key set and group count, and checks every
// popped result in order. Both queue sides idle at random.
// ----------------------------------------------------------------------------
module testbench import dkgs_pkg::*;;

	localparam logic [APB_AW-1:0] ADDR_SPARE = 3'd4;
	localparam int                TAIL_ITEMS = 40;
	localparam logic [APB_DW-1:0] LIMIT_SEQ [14] = '{
		32'h0000_0000, 32'h0000_0021, 32'h0000_001F, 32'h0000_0010,
		32'h0000_0003, 32'hABCD_EF05, 32'h0000_0002, 32'h0000_0008,
		32'hFFFF_FFE1, 32'h0000_000C, 32'h0000_0011, 32'hFFFF_FFFF,
		32'h0000_0004, 32'h0000_000F
	};

	class group_tag_board;
		logic [SUBJ_W-1:0]  key_store [MAX_KEYS_DEF];
		bit                 key_valid [MAX_KEYS_DEF];
		int                 keys_held;
		logic [GROUP_W-1:0] group;
		logic [CFG_W-1:0]   limit;
		out_item_t          pending_tags [$];
		int                 errors;

		function new();
			clear_keys();
			group  = '0;
			limit  = CFG_RESET;
			errors = 0;
		endfunction

		function void clear_keys();
			for (int i = 0; i < MAX_KEYS_DEF; i++) begin
				key_store[i] = '0;
				key_valid[i] = 1'b0;
			end
			keys_held = 0;
		endfunction

		function void write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
			if (addr == ADDR_SUBJECTS) begin
				limit = data[CFG_W-1:0];
			end
		endfunction

		function void check_limit(input logic [APB_DW-1:0] got);
			if (got !== APB_DW'(limit)) begin
				errors++;
				if (errors <= 10) begin
					$display("limit readback: expected %0d, got %0d", limit, got);
				end
			end
		endfunction

		function void note_request(input in_item_t req);
			out_item_t tag;
			bit        seen;
			int        lim;
			seen = 1'b0;
			if (req.start_of_set) begin
				clear_keys();
				group = '0;
			end
			tag.opened_group = (keys_held == 0);
			for (int i = 0; i < MAX_KEYS_DEF; i++) begin
				if (key_valid[i] && key_store[i] == req.subject_key) begin
					seen = 1'b1;
				end
			end
			tag.new_key = !seen;
			if (!seen) begin
				lim = (limit < LIMIT_MIN) ? LIMIT_MIN : int'(limit);
				if (lim > MAX_KEYS_DEF) begin
					lim = MAX_KEYS_DEF;
				end
				if (keys_held >= lim) begin
					clear_keys();
					if (group != GROUP_MAX) begin
						group++;
					end
					tag.opened_group = 1'b1;
				end
				if (keys_held < MAX_KEYS_DEF) begin
					key_store[keys_held] = req.subject_key;
					key_valid[keys_held] = 1'b1;
					keys_held++;
				end
			end
			tag.group_number = group;
			pending_tags.push_back(tag);
		endfunction

		function void check_result(input out_item_t got);
			out_item_t want;
			if (pending_tags.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected result: group %0d opened %0b new %0b",
						got.group_number, got.opened_group, got.new_key);
				end
				return;
			end
			want = pending_tags.pop_front();
			if (got.group_number !== want.group_number ||
					got.opened_group !== want.opened_group ||
					got.new_key !== want.new_key) begin
				errors++;
				if (errors <= 10) begin
					$display({"result mismatch: expected group %0d opened %0b new %0b, ",
						"got group %0d opened %0b new %0b"},
						want.group_number, want.opened_group, want.new_key,
						got.group_number, got.opened_group, got.new_key);
				end
			end
		endfunction
	endclass

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr   = '0;
	logic [APB_DW-1:0] pwdata  = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              push    = 1'b0;
	logic              full;
	in_item_t          item    = '0;
	logic              pop     = 1'b0;
	logic              empty;
	out_item_t         result;

	group_tag_board tags = new();
	bit             calm = 1'b0;
	int             sent = 0;

	distinct_key_group_splitter i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.full    (full),
		.item    (item),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	always #2 clk = ~clk;

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 13);
	endfunction

	always @(posedge clk) begin
		if (pop && !empty) begin
			tags.check_result(result);
		end
		pop <= arst_n && !idle_now();
	end

	task automatic send_request(input logic [SUBJ_W-1:0] key, input logic start);
		in_item_t req;
		req.subject_key  = key;
		req.start_of_set = start;
		while (idle_now()) begin
			push <= 1'b0;
			@(posedge clk);
		end
		item <= req;
		push <= 1'b1;
		do @(posedge clk); while (full);
		tags.note_request(req);
		sent++;
	endtask

	task automatic settle();
		push <= 1'b0;
		while (tags.pending_tags.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		logic [APB_DW-1:0] rd;
		apb_access(1'b1, addr, data, rd);
		tags.write_reg(addr, data);
		apb_access(1'b0, ADDR_SUBJECTS, '0, rd);
		tags.check_limit(rd);
	endtask

	task automatic send_data_set(input int len, input int step_max);
		logic [SUBJ_W-1:0] key;
		key = $urandom_range(65535);
		for (int n = 0; n < len; n++) begin
			if (n != 0 && $urandom_range(99) >= 40) begin
				key = key + SUBJ_W'($urandom_range(step_max, 1));
			end
			send_request(key, n == 0);
		end
	endtask

	initial begin
		#4_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		int goal;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit: first request opens group 0 without a start flag
		send_request(16'h0000, 1'b0);
		send_request(16'h0000, 1'b0);
		send_request(16'h0001, 1'b0);
		send_request(16'hFFFF, 1'b0);
		send_request(16'h0001, 1'b0);
		send_request(16'hFFFF, 1'b0);
		send_request(16'hAAAA, 1'b0);
		send_request(16'h5555, 1'b1);
		send_request(16'h5555, 1'b0);
		settle();

		// limit 17 acts as the full store
		write_reg(ADDR_SUBJECTS, 32'h0000_0011);
		for (int k = 0; k < 17; k++) begin
			send_request(SUBJ_W'(k * 3855), k == 0);
		end

		for (int p = 0; p < 14; p++) begin
			settle();
			write_reg(ADDR_SUBJECTS, LIMIT_SEQ[p]);
			if (p == 6) begin
				write_reg(ADDR_SPARE, $urandom());
			end
			calm = (p == 9);
			goal = sent + 85;
			while (sent < goal) begin
				if ($urandom_range(99) < 85) begin
					send_data_set($urandom_range(48, 1), $urandom_range(1) ? 3 : 5000);
				end else begin
					send_request(SUBJ_W'($urandom()), $urandom_range(99) < 10);
				end
			end
		end

		// calm run at the smallest limit, then a new data set
		settle();
		write_reg(ADDR_SUBJECTS, 32'h0000_0002);
		calm = 1'b1;
		for (int k = 0; k < TAIL_ITEMS; k++) begin
			send_request(SUBJ_W'(k), k == 0);
		end
		send_request(16'h1234, 1'b1);
		send_request(16'h1235, 1'b0);
		calm = 1'b0;
		settle();

		if (tags.errors == 0 && tags.pending_tags.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/dkgs_pkg.sv
rtl/dkgs_classifier.sv
rtl/dkgs_fifo.sv
rtl/distinct_key_group_splitter.sv
bench/testbench.sv
